// ----- hdl/mtfq_pkg.sv -----
// ----------------------------------------------------------------------------
// mtfq_pkg
// Shared types and defaults for the move-to-front queue: request codes,
// status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package mtfq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		MODE_ENQ     = 2'd0,
		MODE_DEQ     = 2'd1,
		MODE_PROMOTE = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_EMPTY     = 2'd1,
		STATUS_NOT_FOUND = 2'd2,
		STATUS_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ,
		ST_DEQ,
		ST_WALK,
		ST_FIX,
		ST_RESP
	} state_t;

endpackage

// ----- hdl/mtfq_ram.sv -----
// ----------------------------------------------------------------------------
// mtfq_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module mtfq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/fifo_with_move_to_front.sv -----
// ----------------------------------------------------------------------------
// fifo_with_move_to_front
// Bounded FIFO held as a linked list in RAM, with dequeue and move-to-front.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_ready) carries one word, mode and
//    item_value: enqueue appends, dequeue pops the head, promote moves the
//    first entry equal to item_value to the front, the fourth code is a no-op.
//  - Response channel (rsp_valid/rsp_ready) returns exactly one word per
//    request: out_value (popped value, else zero), status and entries_held.
//  - One request is in work at a time. Requests answered at once (full,
//    empty, no-op, enqueue to a never-used slot) go straight to ST_RESP;
//    dequeue and enqueue into a recycled slot pass through ST_DEQ or ST_ENQ,
//    and a promote walks the list from the head in ST_WALK, then uses ST_FIX
//    to relink a match found behind the head. req_ready returns in the same
//    cycle as rsp_valid rises.
//  - Values and links live in two RAMs with registered reads; freed slots are
//    chained through the link RAM, and slots never yet used are handed out by
//    a high-water counter, so no clearing pass is needed after reset.
//  - Reset (arst_n low) empties the queue at once; RAM contents are left as
//    they are and are never read before being written.
//  - A response word waiting on a stalled receiver sits in the output
//    register; the next request is still taken and worked, and its response
//    is held back until the output register frees.
// ----------------------------------------------------------------------------
module fifo_with_move_to_front #(
	parameter int unsigned QUEUE_DEPTH = mtfq_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned VALUE_WIDTH = mtfq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  mtfq_pkg::mode_t                    mode,
	input  logic [VALUE_WIDTH-1:0]             item_value,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic [VALUE_WIDTH-1:0]             out_value,
	output mtfq_pkg::status_t                  status,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   entries_held
);

	import mtfq_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

	// Controller and list registers
	state_t          state_q, state_d;
	logic [AW-1:0]   head_q, head_d;
	logic [AW-1:0]   tail_q, tail_d;
	logic [AW-1:0]   free_q, free_d;     // head of the recycled-slot chain
	logic [CW-1:0]   hwm_q, hwm_d;       // slots at or above this never used
	logic [CW-1:0]   count_q, count_d;
	logic            rsp_valid_q, rsp_valid_d;

	// Per-request working registers
	logic [AW-1:0]          cur_q, cur_d;
	logic [AW-1:0]          prev_q, prev_d;
	logic [AW-1:0]          idx_q, idx_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	logic [VALUE_WIDTH-1:0] res_value_q, res_value_d;
	status_t                res_status_q, res_status_d;
	logic [VALUE_WIDTH-1:0] out_value_q, out_value_d;
	status_t                out_status_q, out_status_d;
	logic [CW-1:0]          out_count_q, out_count_d;

	// RAM ports
	logic                   val_we;
	logic [AW-1:0]          val_waddr;
	logic [VALUE_WIDTH-1:0] val_wdata;
	logic [VALUE_WIDTH-1:0] val_rdata;
	logic                   lnk_we;
	logic [AW-1:0]          lnk_waddr;
	logic [AW-1:0]          lnk_wdata;
	logic [AW-1:0]          lnk_rdata;
	logic [AW-1:0]          rd_addr;

	logic accept;
	logic out_free;
	logic walk_last;

	mtfq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(QUEUE_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	mtfq_ram #(.WIDTH(AW), .DEPTH(QUEUE_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.raddr (rd_addr),
		.rdata (lnk_rdata)
	);

	assign req_ready    = (state_q == ST_IDLE);
	assign accept       = req_valid && req_ready;
	assign out_free     = !rsp_valid_q || rsp_ready;
	assign walk_last    = (CW'(idx_q) == count_q - CW'(1));

	assign rsp_valid    = rsp_valid_q;
	assign out_value    = out_value_q;
	assign status       = out_status_q;
	assign entries_held = out_count_q;

	// Next state, RAM control and register updates
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		free_d       = free_q;
		hwm_d        = hwm_q;
		count_d      = count_q;
		rsp_valid_d  = rsp_valid_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		idx_d        = idx_q;
		val_d        = val_q;
		res_value_d  = res_value_q;
		res_status_d = res_status_q;
		out_value_d  = out_value_q;
		out_status_d = out_status_q;
		out_count_d  = out_count_q;

		val_we    = 1'b0;
		val_waddr = hwm_q[AW-1:0];
		val_wdata = item_value;
		lnk_we    = 1'b0;
		lnk_waddr = tail_q;
		lnk_wdata = hwm_q[AW-1:0];
		rd_addr   = (mode == MODE_ENQ) ? free_q : head_q;

		// drop the response word once taken
		if (rsp_valid_q && rsp_ready) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					val_d        = item_value;
					res_value_d  = '0;
					res_status_d = STATUS_DONE;
					state_d      = ST_RESP;
					case (mode)
						MODE_ENQ: begin
							if (count_q == FULL_COUNT) begin
								res_status_d = STATUS_FULL;
							end else if (hwm_q < FULL_COUNT) begin
								// take a never-used slot straight away
								val_we  = 1'b1;
								lnk_we  = (count_q != '0);
								if (count_q == '0) begin
									head_d = hwm_q[AW-1:0];
								end
								tail_d  = hwm_q[AW-1:0];
								count_d = count_q + CW'(1);
								hwm_d   = hwm_q + CW'(1);
							end else begin
								// pop the recycled chain: its link is being read
								cur_d   = free_q;
								state_d = ST_ENQ;
							end
						end
						MODE_DEQ: begin
							if (count_q == '0) begin
								res_status_d = STATUS_EMPTY;
							end else begin
								state_d = ST_DEQ;
							end
						end
						MODE_PROMOTE: begin
							if (count_q == '0) begin
								res_status_d = STATUS_NOT_FOUND;
							end else begin
								cur_d   = head_q;
								prev_d  = head_q;
								idx_d   = '0;
								state_d = ST_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end

			ST_ENQ: begin
				free_d    = lnk_rdata;
				val_we    = 1'b1;
				val_waddr = cur_q;
				val_wdata = val_q;
				lnk_we    = (count_q != '0);
				lnk_wdata = cur_q;
				if (count_q == '0) begin
					head_d = cur_q;
				end
				tail_d  = cur_q;
				count_d = count_q + CW'(1);
				state_d = ST_RESP;
			end

			ST_DEQ: begin
				// return the head and push its slot onto the recycled chain
				res_value_d = val_rdata;
				head_d      = lnk_rdata;
				lnk_we      = 1'b1;
				lnk_waddr   = head_q;
				lnk_wdata   = free_q;
				free_d      = head_q;
				count_d     = count_q - CW'(1);
				state_d     = ST_RESP;
			end

			ST_WALK: begin
				rd_addr = lnk_rdata;
				if (val_rdata == val_q) begin
					if (idx_q == '0) begin
						state_d = ST_RESP;
					end else begin
						// unlink the match from behind its predecessor
						lnk_we    = 1'b1;
						lnk_waddr = prev_q;
						lnk_wdata = lnk_rdata;
						if (walk_last) begin
							tail_d = prev_q;
						end
						state_d = ST_FIX;
					end
				end else if (walk_last) begin
					res_status_d = STATUS_NOT_FOUND;
					state_d      = ST_RESP;
				end else begin
					// advance to the next entry
					prev_d = cur_q;
					cur_d  = lnk_rdata;
					idx_d  = idx_q + AW'(1);
				end
			end

			ST_FIX: begin
				lnk_we    = 1'b1;
				lnk_waddr = cur_q;
				lnk_wdata = head_q;
				head_d    = cur_q;
				state_d   = ST_RESP;
			end

			ST_RESP: begin
				if (out_free) begin
					rsp_valid_d  = 1'b1;
					out_value_d  = res_value_q;
					out_status_d = res_status_q;
					out_count_d  = count_q;
					state_d      = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			free_q      <= '0;
			hwm_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			free_q      <= free_d;
			hwm_q       <= hwm_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		prev_q       <= prev_d;
		idx_q        <= idx_d;
		val_q        <= val_d;
		res_value_q  <= res_value_d;
		res_status_q <= res_status_d;
		out_value_q  <= out_value_d;
		out_status_q <= out_status_d;
		out_count_q  <= out_count_d;
	end

	// Occupancy never exceeds the queue size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above queue depth");

	// Every held entry came from a slot below the high-water mark
	a_hwm_cover: assert property (@(posedge clk) disable iff (!arst_n)
		hwm_q >= count_q)
		else $error("high-water mark below entry count");

	// The walk only visits positions inside the list
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (CW'(idx_q) < count_q))
		else $error("list walk beyond last entry");

	// A response word appears only from the response state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !$past(rsp_valid_q && !rsp_ready)) |-> $past(state_q == ST_RESP))
		else $error("response raised outside the response state");

endmodule

// ----- bench/queue_order_checker.sv -----
// ----------------------------------------------------------------------------
// queue_order_checker
// Watches the request and response channels of the move-to-front queue,
// keeps its own image of the queue order and checks every response word
// field by field against the answer that image predicts.
// ----------------------------------------------------------------------------
module queue_order_checker #(
	parameter int unsigned DEPTH = mtfq_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned WIDTH = mtfq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  logic                             req_ready,
	input  mtfq_pkg::mode_t                  mode,
	input  logic [WIDTH-1:0]                 item_value,
	input  logic                             rsp_valid,
	input  logic                             rsp_ready,
	input  logic [WIDTH-1:0]                 out_value,
	input  mtfq_pkg::status_t                status,
	input  logic [$clog2(DEPTH+1)-1:0]       entries_held,
	output int                               fail_count,
	output int                               outstanding
);

	import mtfq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef struct {
		logic [WIDTH-1:0] value;
		status_t          status;
		logic [CW-1:0]    held;
	} answer_t;

	// Head of the queue at index 0.
	logic [WIDTH-1:0] queue_image[$];
	answer_t          answers_due[$];
	answer_t          want;
	int               fails = 0;

	// Apply one request to the image and return the word it should produce.
	function automatic answer_t next_answer(mode_t m, logic [WIDTH-1:0] v);
		answer_t a;
		int      hit;
		a.value = '0;
		a.status = STATUS_DONE;
		hit = -1;
		case (m)
			MODE_ENQ: begin
				if (queue_image.size() >= DEPTH)
					a.status = STATUS_FULL;
				else
					queue_image.push_back(v);
			end
			MODE_DEQ: begin
				if (queue_image.size() == 0)
					a.status = STATUS_EMPTY;
				else
					a.value = queue_image.pop_front();
			end
			MODE_PROMOTE: begin
				for (int i = 0; i < queue_image.size(); i++)
					if (hit < 0 && queue_image[i] == v)
						hit = i;
				if (hit < 0) begin
					a.status = STATUS_NOT_FOUND;
				end else if (hit > 0) begin
					queue_image.delete(hit);
					queue_image.push_front(v);
				end
			end
			default: ;
		endcase
		a.held = CW'(queue_image.size());
		return a;
	endfunction

	// Check the response first: a word leaving in the same cycle as a new
	// request belongs to an older one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_image.delete();
			answers_due.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (answers_due.size() == 0) begin
					$error("response word with no request waiting: out_value %h status %0d",
						out_value, status);
					fails++;
				end else begin
					want = answers_due.pop_front();
					if (out_value !== want.value) begin
						$error("out_value: expected %h, got %h", want.value, out_value);
						fails++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
					if (entries_held !== want.held) begin
						$error("entries_held: expected %0d, got %0d", want.held,
							entries_held);
						fails++;
					end
				end
			end
			if (req_valid && req_ready)
				answers_due.push_back(next_answer(mode, item_value));
		end
		outstanding <= answers_due.size();
		fail_count <= fails;
	end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the move-to-front queue with a directed opening and a long run of
// random requests, idles both channels at random, stalls the receiver for a
// long stretch and pauses the sender until the queue has answered everything.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;
	import mtfq_pkg::*;

	localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
	localparam int unsigned WIDTH = VALUE_WIDTH_DEF;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	localparam int RANDOM_WORDS   = 750;
	localparam int PHASE_WORDS    = 50;    // fill-biased and drain-biased halves
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT    = 3000;  // well above the hold plus a full walk
	localparam int TAIL_CYCLES    = DEPTH + 8;
	localparam int POOL_SIZE      = 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	mode_t            mode = MODE_NOP;
	logic [WIDTH-1:0] item_value = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	logic [WIDTH-1:0] out_value;
	status_t          status;
	logic [CW-1:0]    entries_held;

	int               fail_count;
	int               outstanding;

	// Shared between the sender and the receiver process.
	bit               steady = 1'b0;   // no idling on either side while set
	int               holds_asked = 0;
	int               holds_done = 0;

	int               words_sent = 0;
	int               directed_words = 0;
	int               quiet_cycles = 0;
	logic [WIDTH-1:0] pool[POOL_SIZE];

	fifo_with_move_to_front #(
		.QUEUE_DEPTH(DEPTH),
		.VALUE_WIDTH(WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.mode(mode),
		.item_value(item_value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.out_value(out_value),
		.status(status),
		.entries_held(entries_held)
	);

	queue_order_checker #(
		.DEPTH(DEPTH),
		.WIDTH(WIDTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.mode(mode),
		.item_value(item_value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.out_value(out_value),
		.status(status),
		.entries_held(entries_held),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one word and hold it until the block takes it; then, unless a
	// steady stretch is on, drop valid for a short random gap now and then.
	// Valid is left high when no gap follows, so the next word is offered
	// straight after this one is taken.
	task automatic send_word(mode_t m, logic [WIDTH-1:0] v);
		mode <= m;
		item_value <= v;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		words_sent++;
		if (!steady && $urandom_range(99) < 23) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// Hold the sender back until every word sent has been answered.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Mostly values from a small pool, so promotes hit and duplicates occur;
	// now and then a fully random value to exercise every bit.
	function automatic logic [WIDTH-1:0] pick_value();
		if ($urandom_range(9) == 0)
			return WIDTH'($urandom);
		return pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	// Receiver: random back-pressure, a clean run while steady is set, and a
	// long hold-off whenever the sender asks for one.
	initial begin
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				rsp_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else if (steady) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= ($urandom_range(99) >= 23);
			end
		end
	end

	// Count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int    step;
		int    random_sent;
		int    roll;
		bit    filling;
		mode_t m;

		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = WIDTH'($urandom);
		// Two pool values close together so some walks compare near misses.
		pool[1] = pool[0] ^ WIDTH'(1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: dequeue, promote, and the no-op code.
		send_word(MODE_DEQ, '0);
		send_word(MODE_PROMOTE, '1);
		send_word(MODE_NOP, '1);

		// Four entries at the value extremes and two alternating patterns.
		send_word(MODE_ENQ, '0);
		send_word(MODE_ENQ, '1);
		send_word(MODE_ENQ, WIDTH'(32'hA5A5A5A5));
		send_word(MODE_ENQ, WIDTH'(32'h5A5A5A5A));

		// Promote the tail, then the head, then a middle entry, then a miss.
		send_word(MODE_PROMOTE, WIDTH'(32'h5A5A5A5A));
		send_word(MODE_PROMOTE, WIDTH'(32'h5A5A5A5A));
		send_word(MODE_PROMOTE, '1);
		send_word(MODE_PROMOTE, WIDTH'(32'h12345678));

		// Fill to capacity behind the moved tail, with duplicates, then overflow.
		for (int i = 4; i < DEPTH; i++)
			send_word(MODE_ENQ, pool[i % 3]);
		send_word(MODE_ENQ, pool[3]);

		// Promote a duplicated value, which must take the first match only.
		send_word(MODE_PROMOTE, pool[1]);
		send_word(MODE_DEQ, '0);
		directed_words = words_sent;

		// Random part: alternate fill-biased and drain-biased phases so the
		// queue swings between empty and full many times over.
		step = 0;
		random_sent = 0;
		while (random_sent < RANDOM_WORDS) begin
			if (step == 200)
				holds_asked++;        // long receiver stall while words keep coming
			if (step == 400)
				wait_drained();       // sender pauses until the queue has answered all
			steady = (step >= 450 && step < 560);
			filling = ((random_sent / PHASE_WORDS) % 2) == 0;
			roll = $urandom_range(99);
			if (roll < 3)
				m = MODE_NOP;
			else if (roll < 25)
				m = MODE_PROMOTE;
			else if (roll < (filling ? 75 : 45))
				m = MODE_ENQ;
			else
				m = MODE_DEQ;
			send_word(m, pick_value());
			if (m != MODE_NOP)
				random_sent++;
			step++;
		end
		steady = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d request words (%0d directed, the rest random) over",
			words_sent, directed_words);
		$display("fill and drain phases, promotes with duplicates, a long stall and a drain pause.");
		if (fail_count == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
